// ===== hdl/crn_pkg.sv =====
// Shared types and constants for the credit ring node.
// No dependencies; the node, datapath, controller and testbench refer to it by scoped names.
`timescale 1ns / 1ps

package crn_pkg;

  // width of the remainder unit operands (ring size and next id need 9 bits)
  localparam int DIV_W = 9;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OWN_ID      = 2'd0,
    CFG_RING_SIZE   = 2'd1,
    CFG_QUEUE_LIMIT = 2'd2
  } cfg_index_e;

  // register reset values
  localparam logic [7:0] OWN_ID_RESET      = 8'd1;
  localparam logic [8:0] RING_SIZE_RESET   = 9'd5;
  localparam logic [6:0] QUEUE_LIMIT_RESET = 7'd50;

  // input commands
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_PROBE  = 3'd2,
    CMD_CREDIT = 3'd3,
    CMD_START  = 3'd4
  } cmd_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_CREDIT   = 3'd1,
    KIND_PROBE    = 3'd2,
    KIND_DEADLOCK = 3'd3,
    KIND_CONSUMED = 3'd4,
    KIND_DROPPED  = 3'd5
  } kind_e;

  // result field source select
  typedef enum logic [2:0] {
    SEL_OWN_PROBE = 3'd0,
    SEL_GEN       = 3'd1,
    SEL_HEAD      = 3'd2,
    SEL_CREDIT    = 3'd3,
    SEL_ECHO      = 3'd4
  } sel_e;

  // controller states
  typedef enum logic [3:0] {
    ST_NID_GO   = 4'd0,
    ST_NID_WAIT = 4'd1,
    ST_IDLE     = 4'd2,
    ST_DECIDE   = 4'd3,
    ST_PROBE    = 4'd4,
    ST_GEN_WAIT = 4'd5,
    ST_GEN      = 4'd6,
    ST_SEND     = 4'd7,
    ST_CREDIT   = 4'd8,
    ST_ECHO     = 4'd9
  } state_e;

  // one input item
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] msg_source;
    logic [7:0] msg_dest;
    logic       msg_waiting;
    logic [6:0] credit_value;
    logic       coin_a;
    logic       coin_b;
    logic [7:0] gen_dest;
  } item_t;

  // one result item
  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_source;
    logic [7:0] out_dest;
    logic       out_waiting;
    logic [6:0] out_credits;
    logic       out_last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  push;
    logic  pop;
    logic  load_credits;
    logic  div_start;
    logic  div_nid;
    logic  nid_load;
    logic  emit;
    sel_e  sel;
    kind_e kind;
    logic  last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic credits_zero;
    logic me_zero;
    logic coin_any;
    logic queue_empty;
    logic head_to_next;
    logic room;
    logic dst_is_me;
    logic src_is_me;
    logic waiting;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/credit_ring_node_with_deadlock_probe.sv =====
// Ring node with message queue, credit flow control and deadlock probe.
// Each item is captured and decided, then its results (0 to 3) follow; a generated
// message first waits on the iterative remainder unit. Results come one per cycle from a
// registered strobe, in the cycle after the controller emits them; no stall.
// After reset, and after a write to own_id or ring_size, busy stays high
// while the next-node id is worked out; the queue needs no clearing.
// Depends on crn_pkg, crn_ctrl and crn_datapath.
`timescale 1ns / 1ps

module credit_ring_node_with_deadlock_probe #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  crn_pkg::item_t                  item,
  output logic                            result_valid,
  output crn_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  crn_pkg::ctrl_cmd_t  cmd;
  crn_pkg::dp_status_t status;
  logic                cfg_we;
  logic                cfg_nid_write;

  // config write, and whether it moves the next-node id
  assign cfg_we        = cfg_valid && cfg_ready;
  assign cfg_nid_write = cfg_we && (cfg_index == crn_pkg::CFG_OWN_ID ||
                                    cfg_index == crn_pkg::CFG_RING_SIZE);

  crn_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cfg_nid_write (cfg_nid_write),
    .status        (status),
    .busy          (busy),
    .cfg_ready     (cfg_ready),
    .cmd           (cmd)
  );

  crn_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== hdl/crn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crn_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/crn_mod.sv =====
// Iterative remainder unit: one restoring step per cycle.
// No dependencies.
`timescale 1ns / 1ps

module crn_mod #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    dvd;
  logic [W-1:0]    dsr;
  logic [W:0]      rem;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;

  // one trial subtraction per step
  assign trial = {rem[W-1:0], dvd[W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= CntW'(W);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // operand and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= dvd << 1;
      rem <= fits ? diff : trial;
    end
  end

  assign remainder = rem[W-1:0];

endmodule

// ===== hdl/crn_datapath.sv =====
// Datapath of the ring node: config registers, item register, queue,
// credit state, next-id remainder unit and result register.
// Depends on crn_pkg, crn_ram and crn_mod.
`timescale 1ns / 1ps

module crn_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  crn_pkg::item_t                      item,
  input  logic                                cfg_we,
  input  logic [crn_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [crn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  crn_pkg::ctrl_cmd_t                  cmd,
  output crn_pkg::dp_status_t                 status,
  output logic                                result_valid,
  output crn_pkg::result_t                    result
);

  localparam int AddrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int LimW   = (CntW > 7) ? CntW : 7;
  localparam int CmpW   = (ID_WIDTH > crn_pkg::DIV_W) ? ID_WIDTH : crn_pkg::DIV_W;
  localparam int EntryW = 2 * ID_WIDTH + 1;

  logic [7:0]                own_id;
  logic [8:0]                ring_size;
  logic [6:0]                queue_limit;
  crn_pkg::item_t            item_q;
  logic [AddrW-1:0]          head;
  logic [AddrW-1:0]          tail;
  logic [CntW-1:0]           count;
  logic [6:0]                credits_held;
  logic [crn_pkg::DIV_W-1:0] nid;

  logic [ID_WIDTH-1:0]       me;
  logic [ID_WIDTH-1:0]       in_src;
  logic [ID_WIDTH-1:0]       in_dst;
  logic [EntryW-1:0]         rdata;
  logic [ID_WIDTH-1:0]       head_src;
  logic [ID_WIDTH-1:0]       head_dst;
  logic                      head_wait;
  logic [crn_pkg::DIV_W-1:0] eff_ring;
  logic [crn_pkg::DIV_W-1:0] div_dividend;
  logic [crn_pkg::DIV_W-1:0] div_rem;
  logic                      div_done;
  logic [LimW-1:0]           lim;
  logic [LimW-1:0]           count_ext;
  logic [6:0]                credit_out;
  crn_pkg::result_t          result_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id      <= crn_pkg::OWN_ID_RESET;
      ring_size   <= crn_pkg::RING_SIZE_RESET;
      queue_limit <= crn_pkg::QUEUE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        crn_pkg::CFG_OWN_ID:      own_id      <= cfg_data[7:0];
        crn_pkg::CFG_RING_SIZE:   ring_size   <= cfg_data;
        crn_pkg::CFG_QUEUE_LIMIT: queue_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  // id views at the configured id width
  assign me     = ID_WIDTH'(own_id);
  assign in_src = ID_WIDTH'(item_q.msg_source);
  assign in_dst = ID_WIDTH'(item_q.msg_dest);

  // queue storage, head entry read every cycle
  crn_ram #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail),
    .wdata ({in_src, in_dst, item_q.msg_waiting}),
    .raddr (head),
    .rdata (rdata)
  );

  assign head_src  = rdata[EntryW-1 -: ID_WIDTH];
  assign head_dst  = rdata[ID_WIDTH:1];
  assign head_wait = rdata[0];

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (32'(tail) + 1 >= QUEUE_DEPTH) ? '0 : tail + 1'b1;
      end
      if (cmd.pop) begin
        head <= (32'(head) + 1 >= QUEUE_DEPTH) ? '0 : head + 1'b1;
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        count <= count - 1'b1;
      end
    end
  end

  // credits from the next node
  always_ff @(posedge clk) begin
    if (rst) begin
      credits_held <= '0;
    end else if (cmd.load_credits) begin
      credits_held <= item_q.credit_value;
    end
  end

  // remainder unit, shared by next id and generated destination
  assign eff_ring     = (ring_size == '0) ? crn_pkg::DIV_W'(1) : ring_size;
  assign div_dividend = cmd.div_nid ? ({1'b0, own_id} + crn_pkg::DIV_W'(1))
                                    : crn_pkg::DIV_W'(item_q.gen_dest);

  crn_mod #(
    .W (crn_pkg::DIV_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (eff_ring),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next node id
  always_ff @(posedge clk) begin
    if (cmd.nid_load) begin
      nid <= div_rem;
    end
  end

  // free slots: clamped limit minus occupancy, floor at zero
  assign lim = (LimW'(queue_limit) > LimW'(QUEUE_DEPTH)) ? LimW'(QUEUE_DEPTH)
                                                         : LimW'(queue_limit);
  assign count_ext  = LimW'(count);
  assign credit_out = (count_ext >= lim) ? 7'd0 : 7'(lim - count_ext);

  // status to the controller
  always_comb begin
    status              = '0;
    status.cmd          = crn_pkg::cmd_e'(item_q.command);
    status.credits_zero = credits_held == '0;
    status.me_zero      = me == '0;
    status.coin_any     = item_q.coin_a | item_q.coin_b;
    status.queue_empty  = count == '0;
    status.head_to_next = CmpW'(head_dst) == CmpW'(nid);
    status.room         = count_ext < lim;
    status.dst_is_me    = in_dst == me;
    status.src_is_me    = in_src == me;
    status.waiting      = item_q.msg_waiting;
    status.div_done     = div_done;
  end

  // result field select
  always_comb begin
    result_next          = '0;
    result_next.out_kind = cmd.kind;
    result_next.out_last = cmd.last;
    case (cmd.sel)
      crn_pkg::SEL_OWN_PROBE: begin
        result_next.out_source  = 8'(me);
        result_next.out_dest    = 8'(me);
        result_next.out_waiting = 1'b1;
      end
      crn_pkg::SEL_GEN: begin
        result_next.out_source = 8'(me);
        result_next.out_dest   = 8'(ID_WIDTH'(div_rem));
      end
      crn_pkg::SEL_HEAD: begin
        result_next.out_source  = 8'(head_src);
        result_next.out_dest    = 8'(head_dst);
        result_next.out_waiting = head_wait;
      end
      crn_pkg::SEL_CREDIT: begin
        result_next.out_credits = credit_out;
      end
      crn_pkg::SEL_ECHO: begin
        result_next.out_source  = 8'(in_src);
        result_next.out_dest    = 8'(in_dst);
        result_next.out_waiting = item_q.msg_waiting;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

  // queue consistency checks
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("queue pop while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count < CntW'(QUEUE_DEPTH))
    else $error("queue push while full");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CntW'(QUEUE_DEPTH)) |-> head == tail)
    else $error("queue pointers disagree with occupancy");

endmodule

// ===== hdl/crn_ctrl.sv =====
// Controller of the ring node: decides the results of an item and
// sequences them one per cycle. Depends on crn_pkg.
`timescale 1ns / 1ps

module crn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                cfg_nid_write,
  input  crn_pkg::dp_status_t status,
  output logic                busy,
  output logic                cfg_ready,
  output crn_pkg::ctrl_cmd_t  cmd
);

  typedef struct packed {
    logic          probe;
    logic          gen;
    logic          send;
    logic          credit;
    logic          echo;
    crn_pkg::kind_e echo_kind;
  } plan_t;

  crn_pkg::state_e state;
  crn_pkg::state_e state_next;
  plan_t           plan;
  plan_t           plan_next;
  plan_t           decided;
  logic            push_ok;

  function automatic crn_pkg::state_e dispatch(input plan_t p);
    crn_pkg::state_e s;
    if (p.probe) begin
      s = crn_pkg::ST_PROBE;
    end else if (p.gen) begin
      s = crn_pkg::ST_GEN_WAIT;
    end else if (p.send) begin
      s = crn_pkg::ST_SEND;
    end else if (p.credit) begin
      s = crn_pkg::ST_CREDIT;
    end else if (p.echo) begin
      s = crn_pkg::ST_ECHO;
    end else begin
      s = crn_pkg::ST_IDLE;
    end
    return s;
  endfunction

  // data message goes into the queue
  assign push_ok = !status.dst_is_me && status.room;

  // results the current item calls for
  always_comb begin
    decided           = '0;
    decided.echo_kind = crn_pkg::KIND_DATA;
    case (status.cmd)
      crn_pkg::CMD_TICK: begin
        decided.probe  = status.credits_zero && status.me_zero;
        decided.gen    = !status.credits_zero && status.coin_any;
        decided.send   = !decided.gen && !status.queue_empty &&
                         (!status.credits_zero || status.head_to_next);
        decided.credit = decided.send;
      end
      crn_pkg::CMD_DATA: begin
        if (push_ok) begin
          decided.credit = 1'b1;
        end else begin
          decided.echo      = 1'b1;
          decided.echo_kind = status.dst_is_me ? crn_pkg::KIND_CONSUMED
                                               : crn_pkg::KIND_DROPPED;
        end
      end
      crn_pkg::CMD_PROBE: begin
        if (status.src_is_me) begin
          decided.echo      = status.waiting && status.credits_zero;
          decided.echo_kind = crn_pkg::KIND_DEADLOCK;
        end else begin
          decided.echo      = status.waiting && status.credits_zero &&
                              (status.queue_empty || !status.head_to_next);
          decided.echo_kind = crn_pkg::KIND_PROBE;
        end
      end
      crn_pkg::CMD_START: begin
        decided.credit = 1'b1;
      end
      default: ;
    endcase
  end

  // next state and remaining results
  always_comb begin
    state_next = state;
    plan_next  = plan;
    case (state)
      crn_pkg::ST_NID_GO: begin
        // a new id or ring size restarts the remainder unit
        if (cfg_nid_write) begin
          state_next = crn_pkg::ST_NID_GO;
        end else begin
          state_next = crn_pkg::ST_NID_WAIT;
        end
      end
      crn_pkg::ST_NID_WAIT: begin
        if (cfg_nid_write) begin
          state_next = crn_pkg::ST_NID_GO;
        end else if (status.div_done) begin
          state_next = crn_pkg::ST_IDLE;
        end
      end
      crn_pkg::ST_IDLE: begin
        if (start) begin
          state_next = crn_pkg::ST_DECIDE;
        end else if (cfg_nid_write) begin
          state_next = crn_pkg::ST_NID_GO;
        end
      end
      crn_pkg::ST_DECIDE: begin
        plan_next  = decided;
        state_next = dispatch(decided);
      end
      crn_pkg::ST_PROBE: begin
        plan_next.probe = 1'b0;
        state_next      = dispatch(plan_next);
      end
      crn_pkg::ST_GEN_WAIT: begin
        if (status.div_done) begin
          state_next = crn_pkg::ST_GEN;
        end
      end
      crn_pkg::ST_GEN: begin
        plan_next.gen = 1'b0;
        state_next    = dispatch(plan_next);
      end
      crn_pkg::ST_SEND: begin
        plan_next.send = 1'b0;
        state_next     = dispatch(plan_next);
      end
      crn_pkg::ST_CREDIT: begin
        plan_next.credit = 1'b0;
        state_next       = dispatch(plan_next);
      end
      crn_pkg::ST_ECHO: begin
        plan_next.echo = 1'b0;
        state_next     = dispatch(plan_next);
      end
      default: begin
        state_next = crn_pkg::ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crn_pkg::ST_NID_GO;
      plan  <= '0;
    end else begin
      state <= state_next;
      plan  <= plan_next;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd      = '0;
    cmd.sel  = crn_pkg::SEL_ECHO;
    cmd.kind = crn_pkg::KIND_DATA;
    cmd.last = dispatch(plan_next) == crn_pkg::ST_IDLE;
    case (state)
      crn_pkg::ST_NID_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_nid   = 1'b1;
      end
      crn_pkg::ST_NID_WAIT: begin
        cmd.nid_load = status.div_done;
      end
      crn_pkg::ST_IDLE: begin
        cmd.capture = start;
      end
      crn_pkg::ST_DECIDE: begin
        cmd.push         = status.cmd == crn_pkg::CMD_DATA && push_ok;
        cmd.load_credits = status.cmd == crn_pkg::CMD_CREDIT;
        cmd.div_start    = decided.gen;
      end
      crn_pkg::ST_PROBE: begin
        cmd.emit = 1'b1;
        cmd.sel  = crn_pkg::SEL_OWN_PROBE;
        cmd.kind = crn_pkg::KIND_PROBE;
      end
      crn_pkg::ST_GEN: begin
        cmd.emit = 1'b1;
        cmd.sel  = crn_pkg::SEL_GEN;
        cmd.kind = crn_pkg::KIND_DATA;
      end
      crn_pkg::ST_SEND: begin
        cmd.emit = 1'b1;
        cmd.pop  = 1'b1;
        cmd.sel  = crn_pkg::SEL_HEAD;
        cmd.kind = crn_pkg::KIND_DATA;
      end
      crn_pkg::ST_CREDIT: begin
        cmd.emit = 1'b1;
        cmd.sel  = crn_pkg::SEL_CREDIT;
        cmd.kind = crn_pkg::KIND_CREDIT;
      end
      crn_pkg::ST_ECHO: begin
        cmd.emit = 1'b1;
        cmd.sel  = crn_pkg::SEL_ECHO;
        cmd.kind = plan.echo_kind;
      end
      default: ;
    endcase
  end

  // config is held off while an item is being accepted
  assign busy      = state != crn_pkg::ST_IDLE;
  assign cfg_ready = (state == crn_pkg::ST_IDLE && !start) ||
                     state == crn_pkg::ST_NID_GO || state == crn_pkg::ST_NID_WAIT;

  // sequencing checks
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> state == crn_pkg::ST_IDLE)
    else $error("last result not followed by idle");

  a_gen_has_credits: assert property (@(posedge clk) disable iff (rst)
    (state == crn_pkg::ST_DECIDE && cmd.div_start) |-> !status.credits_zero)
    else $error("message generated without credits");

  a_pop_before_credit: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> state == crn_pkg::ST_CREDIT)
    else $error("forwarded message not followed by credit");

endmodule

// ===== tb/tb_credit_ring_node_with_deadlock_probe.sv =====
// Self-checking testbench for the credit ring node with deadlock probe.
// Predicts every result from its own copy of node state and checks it in order.
// Depends on crn_pkg and credit_ring_node_with_deadlock_probe.
`timescale 1ns / 1ps

module tb_credit_ring_node_with_deadlock_probe;

  localparam int FIFO_SLOTS    = 64;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 24;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  crn_pkg::item_t                  item = '0;
  logic                            result_valid;
  crn_pkg::result_t                result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [crn_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [crn_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // predicted node state
  logic [7:0]  node_id = crn_pkg::OWN_ID_RESET;
  logic [8:0]  ring_nodes = crn_pkg::RING_SIZE_RESET;
  logic [6:0]  fill_limit = crn_pkg::QUEUE_LIMIT_RESET;
  logic [7:0]  fifo_src [FIFO_SLOTS];
  logic [7:0]  fifo_dst [FIFO_SLOTS];
  logic        fifo_wait [FIFO_SLOTS];
  int unsigned fifo_rd = 0;
  int unsigned fifo_wr = 0;
  int unsigned fifo_fill = 0;
  logic [6:0]  credits_seen = '0;

  crn_pkg::result_t due_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      results_seen = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      send_idle_pct = 0;

  credit_ring_node_with_deadlock_probe dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // effective queue limit, clamped to the queue depth
  function automatic int unsigned limit_now();
    return (fill_limit > FIFO_SLOTS) ? FIFO_SLOTS : fill_limit;
  endfunction

  // a zero ring size counts as one node
  function automatic int unsigned ring_now();
    return (ring_nodes == 0) ? 1 : ring_nodes;
  endfunction

  // next node id at full width, may be 256
  function automatic int unsigned next_node();
    return (node_id + 1) % ring_now();
  endfunction

  function automatic crn_pkg::result_t node_result(crn_pkg::kind_e kind, logic [7:0] src,
                                                   logic [7:0] dst, logic waiting,
                                                   logic [6:0] credits);
    crn_pkg::result_t r;
    r.out_kind    = kind;
    r.out_source  = src;
    r.out_dest    = dst;
    r.out_waiting = waiting;
    r.out_credits = credits;
    r.out_last    = 1'b0;
    return r;
  endfunction

  // free slots reported upstream, saturating at zero
  function automatic crn_pkg::result_t credit_report();
    int unsigned lim;
    lim = limit_now();
    return node_result(crn_pkg::KIND_CREDIT, '0, '0, 1'b0,
                       (fifo_fill >= lim) ? 7'd0 : 7'(lim - fifo_fill));
  endfunction

  function automatic string show(crn_pkg::result_t r);
    return $sformatf("kind %0d src %0d dst %0d wait %0d cred %0d last %0d", r.out_kind,
                     r.out_source, r.out_dest, r.out_waiting, r.out_credits, r.out_last);
  endfunction

  function automatic crn_pkg::item_t node_item(logic [2:0] cmd, logic [7:0] src,
                                               logic [7:0] dst, logic waiting,
                                               logic [6:0] cval, logic ca, logic cb,
                                               logic [7:0] gd);
    crn_pkg::item_t it;
    it.command      = cmd;
    it.msg_source   = src;
    it.msg_dest     = dst;
    it.msg_waiting  = waiting;
    it.credit_value = cval;
    it.coin_a       = ca;
    it.coin_b       = cb;
    it.gen_dest     = gd;
    return it;
  endfunction

  // work out the results of one accepted item and queue them
  task automatic predict_node_outputs(input crn_pkg::item_t it);
    crn_pkg::result_t outs [$];
    crn_pkg::result_t r;
    logic             generated;
    int unsigned      nxt;
    nxt = next_node();
    generated = 1'b0;
    case (it.command)
      crn_pkg::CMD_TICK: begin
        if (credits_seen == 0 && node_id == 0)
          outs.push_back(node_result(crn_pkg::KIND_PROBE, node_id, node_id, 1'b1, '0));
        if (credits_seen != 0 && (it.coin_a || it.coin_b)) begin
          generated = 1'b1;
          outs.push_back(node_result(crn_pkg::KIND_DATA, node_id,
                                     8'(it.gen_dest % ring_now()), 1'b0, '0));
        end
        // forward the head when credits allow or it is bound for the next node
        if (!generated && fifo_fill > 0 &&
            (credits_seen != 0 || fifo_dst[fifo_rd] == nxt)) begin
          outs.push_back(node_result(crn_pkg::KIND_DATA, fifo_src[fifo_rd],
                                     fifo_dst[fifo_rd], fifo_wait[fifo_rd], '0));
          fifo_rd = (fifo_rd + 1) % FIFO_SLOTS;
          fifo_fill--;
          outs.push_back(credit_report());
        end
      end
      crn_pkg::CMD_DATA: begin
        if (it.msg_dest != node_id && fifo_fill < limit_now()) begin
          fifo_src[fifo_wr]  = it.msg_source;
          fifo_dst[fifo_wr]  = it.msg_dest;
          fifo_wait[fifo_wr] = it.msg_waiting;
          fifo_wr = (fifo_wr + 1) % FIFO_SLOTS;
          fifo_fill++;
          outs.push_back(credit_report());
        end else if (it.msg_dest == node_id) begin
          outs.push_back(node_result(crn_pkg::KIND_CONSUMED, it.msg_source, it.msg_dest,
                                     it.msg_waiting, '0));
        end else begin
          outs.push_back(node_result(crn_pkg::KIND_DROPPED, it.msg_source, it.msg_dest,
                                     it.msg_waiting, '0));
        end
      end
      crn_pkg::CMD_PROBE: begin
        if (it.msg_source == node_id) begin
          if (it.msg_waiting && credits_seen == 0)
            outs.push_back(node_result(crn_pkg::KIND_DEADLOCK, it.msg_source,
                                       it.msg_dest, 1'b1, '0));
        end else if (it.msg_waiting) begin
          if (credits_seen == 0 && (fifo_fill == 0 || fifo_dst[fifo_rd] != nxt))
            outs.push_back(node_result(crn_pkg::KIND_PROBE, it.msg_source, it.msg_dest,
                                       1'b1, '0));
        end
      end
      crn_pkg::CMD_CREDIT: credits_seen = it.credit_value;
      crn_pkg::CMD_START:  outs.push_back(credit_report());
      default: ;
    endcase
    for (int i = 0; i < outs.size(); i++) begin
      r = outs[i];
      r.out_last = (i == outs.size() - 1);
      due_results.push_back(r);
    end
  endtask

  task automatic load_register(input logic [crn_pkg::CFG_INDEX_W-1:0] idx,
                               input logic [crn_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      crn_pkg::CFG_OWN_ID:      node_id = val[7:0];
      crn_pkg::CFG_RING_SIZE:   ring_nodes = val;
      crn_pkg::CFG_QUEUE_LIMIT: fill_limit = val[6:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input crn_pkg::result_t got);
    crn_pkg::result_t want;
    string            diffs;
    if (due_results.size() == 0) begin
      report_mismatch({"result with nothing due: ", show(got)});
      return;
    end
    want = due_results.pop_front();
    diffs = "";
    if (got.out_kind !== want.out_kind)       diffs = {diffs, " kind"};
    if (got.out_source !== want.out_source)   diffs = {diffs, " source"};
    if (got.out_dest !== want.out_dest)       diffs = {diffs, " dest"};
    if (got.out_waiting !== want.out_waiting) diffs = {diffs, " waiting"};
    if (got.out_credits !== want.out_credits) diffs = {diffs, " credits"};
    if (got.out_last !== want.out_last)       diffs = {diffs, " last"};
    if (diffs != "")
      report_mismatch($sformatf("result %0d differs in%s: got %s, want %s", results_seen,
                                diffs, show(got), show(want)));
    results_seen++;
  endtask

  // sample handshakes, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (result_valid) check_result(result);
      if (start && !busy) predict_node_outputs(item);
      if ((cfg_valid && cfg_ready) || result_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** credit_ring_node_with_deadlock_probe: FAILED **");
        $finish;
      end
    end
  end

  // offer one item, with a random gap first; start stays high on return
  task automatic send_item(input crn_pkg::item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait until every due result has come and the node is idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(input crn_pkg::cfg_index_e idx,
                                input logic [crn_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_node(input logic [7:0] own, input logic [8:0] ring,
                          input logic [6:0] lim);
    write_register(crn_pkg::CFG_OWN_ID, 9'(own));
    write_register(crn_pkg::CFG_RING_SIZE, ring);
    write_register(crn_pkg::CFG_QUEUE_LIMIT, 9'(lim));
  endtask

  // reset settings: queueing, consuming, probes, generation, forwarding
  task automatic test_basic_traffic();
    send_idle_pct = 10;
    send_item(node_item(crn_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_DATA, 8'h00, 8'd1, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_DATA, 8'hff, 8'hff, 1'b1, 7'h7f, 1'b1, 1'b1, 8'hff));
    send_item(node_item(crn_pkg::CMD_DATA, 8'd7, 8'd2, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    // no credits and head not bound for the next node: nothing happens
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b1, 1'b1, 8'h00));
    send_item(node_item(crn_pkg::CMD_PROBE, 8'd3, 8'd0, 1'b1, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_PROBE, 8'd1, 8'd9, 1'b1, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_CREDIT, 8'h00, 8'h00, 1'b0, 7'h7f, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b1, 1'b0, 8'hff));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    // without credits the head still goes when bound for the next node
    send_item(node_item(crn_pkg::CMD_CREDIT, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(3'd7, 8'hff, 8'hff, 1'b1, 7'h7f, 1'b1, 1'b1, 8'hff));
  endtask

  // node 0 on a zero-size ring launches and gets back its own probe
  task automatic test_initiator_deadlock();
    set_node(8'd0, 9'd0, 7'd50);
    send_item(node_item(crn_pkg::CMD_CREDIT, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b1, 1'b0, 8'd200));
    send_item(node_item(crn_pkg::CMD_PROBE, 8'd0, 8'd0, 1'b1, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_DATA, 8'd5, 8'd0, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_CREDIT, 8'h00, 8'h00, 1'b0, 7'd5, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b1, 8'd200));
  endtask

  // zero limit, full queue, limit below occupancy, oversized limit
  task automatic test_queue_limits();
    set_node(8'd1, 9'd5, 7'd0);
    send_item(node_item(crn_pkg::CMD_DATA, 8'd9, 8'd3, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    write_register(crn_pkg::CFG_QUEUE_LIMIT, 9'd2);
    repeat (3)
      send_item(node_item(crn_pkg::CMD_DATA, 8'd9, 8'd3, 1'b1, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_DATA, 8'd9, 8'd1, 1'b1, 7'h00, 1'b0, 1'b0, 8'h00));
    write_register(crn_pkg::CFG_QUEUE_LIMIT, 9'd1);
    send_item(node_item(crn_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    write_register(crn_pkg::CFG_QUEUE_LIMIT, 9'd127);
    send_item(node_item(crn_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
  endtask

  // highest id: next id 256 matches nothing, then wraps to 0
  task automatic test_id_extremes();
    set_node(8'd255, 9'd300, 7'd64);
    send_item(node_item(crn_pkg::CMD_CREDIT, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_PROBE, 8'd2, 8'd0, 1'b1, 7'h00, 1'b0, 1'b0, 8'h00));
    write_register(crn_pkg::CFG_RING_SIZE, 9'd256);
    send_item(node_item(crn_pkg::CMD_DATA, 8'd1, 8'd255, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_CREDIT, 8'h00, 8'h00, 1'b0, 7'd64, 1'b0, 1'b0, 8'h00));
    send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b1, 1'b1, 8'hff));
    repeat (2)
      send_item(node_item(crn_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0, 8'h00));
  endtask

  // random item biased toward messages for this node or the next, own probes
  function automatic crn_pkg::item_t random_traffic();
    crn_pkg::item_t it;
    int unsigned    pick;
    pick = $urandom_range(99);
    it.msg_source   = 8'($urandom);
    it.msg_dest     = 8'($urandom);
    it.msg_waiting  = 1'($urandom);
    it.credit_value = 7'($urandom_range(64));
    it.coin_a       = 1'($urandom);
    it.coin_b       = 1'($urandom);
    it.gen_dest     = 8'($urandom);
    it.command      = crn_pkg::CMD_TICK;
    if (pick >= 30 && pick < 58) begin
      it.command = crn_pkg::CMD_DATA;
      case ($urandom_range(3))
        0: it.msg_dest = node_id;
        1: it.msg_dest = 8'(next_node());
        default: ;
      endcase
    end else if (pick >= 58 && pick < 72) begin
      it.command = crn_pkg::CMD_PROBE;
      it.msg_waiting = ($urandom_range(3) != 0);
      if ($urandom_range(2) == 0) it.msg_source = node_id;
    end else if (pick >= 72 && pick < 88) begin
      it.command = crn_pkg::CMD_CREDIT;
      if ($urandom_range(1) == 0) it.credit_value = '0;
      else if ($urandom_range(9) == 0) it.credit_value = 7'h7f;
    end else if (pick >= 88 && pick < 96) begin
      it.command = crn_pkg::CMD_START;
    end else if (pick >= 96) begin
      it.command = 3'($urandom_range(7, 5));
    end
    return it;
  endfunction

  // random items under one setting, with a full drain halfway
  task automatic test_random_traffic(input int count, input logic [7:0] own,
                                     input logic [8:0] ring, input logic [6:0] lim,
                                     input int unsigned idle_pct);
    set_node(own, ring, lim);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) settle();
      send_item(random_traffic());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_traffic();
    test_initiator_deadlock();
    test_queue_limits();
    test_id_extremes();
    test_random_traffic(22, 8'd1, 9'd5, 7'd3, 10);
    test_random_traffic(22, 8'd0, 9'd4, 7'd64, 45);
    test_random_traffic(22, 8'($urandom), 9'($urandom_range(511)), 7'($urandom_range(127)), 0);
    test_random_traffic(22, 8'd2, 9'd3, 7'd8, 0);
    settle();
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (mismatch_count == 0) begin
      $display("** credit_ring_node_with_deadlock_probe: PASSED **");
    end else begin
      $display("** credit_ring_node_with_deadlock_probe: FAILED **");
    end
    $finish;
  end

endmodule
